// ===== rtl/core/sgwf_pkg.sv =====
`timescale 1ns / 1ps

package sgwf_pkg;

    // window and field sizes
    localparam int MAX_TAPS    = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 20;
    localparam int IDX_W       = $clog2(MAX_TAPS);
    localparam int TAP_CAP     = ((MAX_TAPS - 1) < 31) ? (MAX_TAPS - 1) : 31;

    localparam int PTS_W      = 5;
    localparam int POS_W      = 5;
    localparam int CMD_W      = 2;
    localparam int SEEN_W     = 6;
    localparam int RECIP_W    = 32;
    localparam int CFG_DATA_W = 32;
    localparam int REG_IDX_W  = 2;
    localparam int OUT_BITS   = 48;
    localparam int FRAC_BITS  = 16;

    localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

    // stream word widths, padded to whole bytes
    localparam int S_TDATA_W = ((POS_W + COEF_BITS + SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((OUT_BITS + 1 + 7) / 8) * 8;

    // datapath widths
    localparam int PROD_W     = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W      = ((PROD_W + IDX_W) < 64) ? (PROD_W + IDX_W) : 64;
    localparam int SPLIT_W    = 32;
    localparam int MAG_W      = (ACC_W > SPLIT_W) ? ACC_W : (SPLIT_W + 1);
    localparam int MH_W       = MAG_W - SPLIT_W;
    localparam int HI_W       = MH_W + RECIP_W;
    localparam int LO_W       = SPLIT_W + RECIP_W;
    localparam int RND_W      = LO_W - FRAC_BITS;
    localparam int HI_LIM_BIT = OUT_BITS - 1 - FRAC_BITS;
    localparam int MAG2_W     = (MAG_W > (OUT_BITS + 1)) ? MAG_W : (OUT_BITS + 1);

    localparam logic [LO_W-1:0]   RND_HALF = LO_W'(1) << (FRAC_BITS - 1);
    localparam logic [MAG2_W-1:0] OVF_MAG  = MAG2_W'(1) << OUT_BITS;
    localparam logic [MAG2_W-1:0] LIM_NEG  = MAG2_W'(1) << (OUT_BITS - 1);
    localparam logic [MAG2_W-1:0] LIM_POS  = LIM_NEG - MAG2_W'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROT,
        S_WAIT
    } state_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD = 2'd0,
        CMD_PUSH = 2'd1,
        CMD_END  = 2'd2
    } cmd_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_LEFT  = 2'd0,
        REG_RIGHT = 2'd1,
        REG_DERIV = 2'd2,
        REG_RECIP = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic shift;
        logic rotate;
        logic clear;
    } cell_ctl_t;

    typedef struct packed {
        logic vld;
        logic en;
        logic first;
        logic last;
    } mac_ctl_t;

    typedef struct packed {
        logic                vld;
        logic                sat;
        logic [OUT_BITS-1:0] value;
    } mac_res_t;

endpackage

// ===== rtl/core/savitzky_golay_window_filter_core.sv =====
`timescale 1ns / 1ps

// Savitzky-Golay window filter core.
// Input words (s_*) carry a command in s_tuser: load a coefficient into window
// position coef_position, push a sample, or end of data. Results (m_*) carry
// the filtered value with 16 fraction bits and a saturation flag; m_tlast marks
// the final result of an end-of-data flush. Registers are written through the
// cfg_* port; the user must write them only while the core is idle, since the
// core itself does not enforce this. Each result takes one pass of the sample
// and coefficient rings through all MAX_TAPS cells into a single
// multiply-accumulate unit and its scaling pipeline, for a push that yields a
// result and for each result of a flush. Coefficient loads and pushes that
// yield no result start no pass, so the core stays ready. A finished result
// sits in the output register, so the core accepts the next word while it
// waits; under a stall on m_tready the core holds its next result in the
// pipeline until the output register frees up.
// Reset (aresetn low, synchronous) clears the sample window, the sample
// count and all handshake state and restores the register defaults;
// coefficients are not cleared and must be loaded before use.
module savitzky_golay_window_filter_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [sgwf_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [sgwf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // coef_position, coef_value, sample, zero pad
    input  logic [sgwf_pkg::S_TDATA_W-1:0]     s_tdata,
    // command
    input  logic [sgwf_pkg::CMD_W-1:0]         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // filtered_value, saturated, zero pad
    output logic [sgwf_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tlast
);
    import sgwf_pkg::*;

    localparam logic [IDX_W-1:0] STEP_LAST = IDX_W'(MAX_TAPS - 1);
    localparam logic [PTS_W-1:0] TAP_CAP_P = PTS_W'(TAP_CAP);

    // config registers
    logic [PTS_W-1:0]   left_reg, right_reg;
    logic               deriv_reg;
    logic [RECIP_W-1:0] recip_reg;

    // control
    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   step_reg, step_next;
    logic [SEEN_W-1:0]  seen_reg, seen_next, seen_inc;
    logic [PTS_W-1:0]   rem_reg, rem_next, flush_n;
    logic               flush_reg, flush_next;

    // output register
    logic                out_vld_reg, out_sat_reg, out_last_reg;
    logic [OUT_BITS-1:0] out_val_reg;

    logic [PTS_W-1:0] r_eff, l_max, l_eff, span_p;
    logic [IDX_W-1:0] span;

    logic [POS_W-1:0]              in_pos;
    logic signed [COEF_BITS-1:0]   in_coef;
    logic signed [SAMPLE_BITS-1:0] in_samp, shift_val;

    cell_ctl_t cell_ctl;
    mac_ctl_t  mac_ctl;
    mac_res_t  mac_res;
    logic      coef_we, take;

    logic signed [SAMPLE_BITS-1:0] samp_q [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] samp_src [MAX_TAPS];
    logic signed [COEF_BITS-1:0]   coef_q [MAX_TAPS];

    assign in_pos  = s_tdata[POS_W-1:0];
    assign in_coef = s_tdata[POS_W +: COEF_BITS];
    assign in_samp = s_tdata[POS_W + COEF_BITS +: SAMPLE_BITS];

    // future taps first, then past taps cut to fit the window
    always_comb begin
        r_eff  = (right_reg < TAP_CAP_P) ? right_reg : TAP_CAP_P;
        l_max  = TAP_CAP_P - r_eff;
        l_eff  = (left_reg < l_max) ? left_reg : l_max;
        span_p = l_eff + r_eff;
        span   = IDX_W'(span_p);
    end

    assign seen_inc = (seen_reg == SEEN_MAX) ? seen_reg : (seen_reg + 1'b1);
    assign flush_n  = (SEEN_W'(r_eff) > seen_reg) ? seen_reg[PTS_W-1:0] : r_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg  <= PTS_W'(2);
            right_reg <= PTS_W'(2);
            deriv_reg <= 1'b0;
            recip_reg <= RECIP_W'(65536);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_LEFT:  left_reg  <= cfg_wdata[PTS_W-1:0];
                REG_RIGHT: right_reg <= cfg_wdata[PTS_W-1:0];
                REG_DERIV: deriv_reg <= cfg_wdata[0];
                REG_RECIP: recip_reg <= cfg_wdata[RECIP_W-1:0];
                default: ;
            endcase
        end
    end

    // cell ring: samples shift up on push and rotate down in a pass,
    // coefficients rotate up, so cell 0 and cell span meet tap by tap
    for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign samp_src[i] = shift_val;
        end else begin : g_body
            assign samp_src[i] = samp_q[i-1];
        end

        sgwf_cell u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .ctl           (cell_ctl),
            .coef_we       (coef_we && (32'(in_pos) == i)),
            .coef_wdata    (in_coef),
            .samp_shift_in (samp_src[i]),
            .samp_rot_in   (samp_q[(i + 1) % MAX_TAPS]),
            .coef_rot_in   (coef_q[(i + MAX_TAPS - 1) % MAX_TAPS]),
            .samp_q        (samp_q[i]),
            .coef_q        (coef_q[i])
        );
    end

    sgwf_mac u_mac (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (mac_ctl),
        .op_samp    (samp_q[0]),
        .op_coef    (coef_q[span]),
        .deriv_mode (deriv_reg),
        .recip_step (recip_reg),
        .res_take   (take),
        .res        (mac_res)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    case (s_tuser)
                        CMD_PUSH: begin
                            if (seen_inc > SEEN_W'(r_eff)) state_next = S_ROT;
                        end
                        CMD_END: begin
                            if (flush_n != '0) state_next = S_ROT;
                        end
                        default: ;
                    endcase
                end
            end
            S_ROT: begin
                if (step_reg == STEP_LAST) state_next = S_WAIT;
            end
            S_WAIT: begin
                if (take) begin
                    state_next = (flush_reg && rem_reg != '0) ? S_ROT : S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = (state_reg == S_IDLE);
        cell_ctl   = '0;
        mac_ctl    = '0;
        coef_we    = 1'b0;
        shift_val  = '0;
        take       = 1'b0;
        step_next  = step_reg;
        seen_next  = seen_reg;
        rem_next   = rem_reg;
        flush_next = flush_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    case (s_tuser)
                        CMD_LOAD: coef_we = 1'b1;
                        CMD_PUSH: begin
                            cell_ctl.shift = 1'b1;
                            shift_val      = in_samp;
                            seen_next      = seen_inc;
                            flush_next     = 1'b0;
                        end
                        CMD_END: begin
                            if (flush_n != '0) begin
                                cell_ctl.shift = 1'b1;
                                rem_next       = flush_n - 1'b1;
                                flush_next     = 1'b1;
                            end else begin
                                cell_ctl.clear = 1'b1;
                                seen_next      = '0;
                                flush_next     = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_ROT: begin
                cell_ctl.rotate = 1'b1;
                mac_ctl.vld     = 1'b1;
                mac_ctl.en      = (step_reg <= span);
                mac_ctl.first   = (step_reg == '0);
                mac_ctl.last    = (step_reg == STEP_LAST);
                step_next       = (step_reg == STEP_LAST) ? '0 : (step_reg + 1'b1);
            end
            S_WAIT: begin
                take = mac_res.vld && (!out_vld_reg || m_tready);
                if (take && flush_reg) begin
                    if (rem_reg != '0) begin
                        cell_ctl.shift = 1'b1;
                        rem_next       = rem_reg - 1'b1;
                    end else begin
                        cell_ctl.clear = 1'b1;
                        seen_next      = '0;
                        flush_next     = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            step_reg    <= '0;
            seen_reg    <= '0;
            rem_reg     <= '0;
            flush_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            seen_reg  <= seen_next;
            rem_reg   <= rem_next;
            flush_reg <= flush_next;
            if (take) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_val_reg  <= mac_res.value;
            out_sat_reg  <= mac_res.sat;
            out_last_reg <= flush_reg && (rem_reg == '0);
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_TDATA_W - OUT_BITS - 1){1'b0}}, out_sat_reg, out_val_reg};

    a_step_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_ROT) |-> (step_reg == '0))
        else $error("pass counter left mid-ring outside a pass");

    a_res_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_res.vld |-> (state_reg == S_WAIT))
        else $error("mac result pending outside the wait state");

    a_flush_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && flush_reg && rem_reg == '0) |=> (seen_reg == '0 && samp_q[0] == '0))
        else $error("window not cleared after the final flush word");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (flush_reg && state_reg != S_IDLE) |-> (rem_reg < r_eff))
        else $error("flush count exceeds the future taps");

endmodule

// ===== rtl/core/sgwf_cell.sv =====
`timescale 1ns / 1ps

module sgwf_cell (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  sgwf_pkg::cell_ctl_t                  ctl,
    input  logic                                 coef_we,
    input  logic signed [sgwf_pkg::COEF_BITS-1:0]   coef_wdata,
    input  logic signed [sgwf_pkg::SAMPLE_BITS-1:0] samp_shift_in,
    input  logic signed [sgwf_pkg::SAMPLE_BITS-1:0] samp_rot_in,
    input  logic signed [sgwf_pkg::COEF_BITS-1:0]   coef_rot_in,
    output logic signed [sgwf_pkg::SAMPLE_BITS-1:0] samp_q,
    output logic signed [sgwf_pkg::COEF_BITS-1:0]   coef_q
);
    import sgwf_pkg::*;

    logic signed [SAMPLE_BITS-1:0] samp_reg, samp_next;
    logic signed [COEF_BITS-1:0]   coef_reg, coef_next;

    // samples: shift up on push, rotate down during a pass
    always_comb begin
        samp_next = samp_reg;
        if (ctl.clear) begin
            samp_next = '0;
        end else if (ctl.shift) begin
            samp_next = samp_shift_in;
        end else if (ctl.rotate) begin
            samp_next = samp_rot_in;
        end
    end

    // coefficients rotate up during a pass, opposite to the samples
    always_comb begin
        coef_next = coef_reg;
        if (coef_we) begin
            coef_next = coef_wdata;
        end else if (ctl.rotate) begin
            coef_next = coef_rot_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            samp_reg <= '0;
        end else begin
            samp_reg <= samp_next;
        end
    end

    always_ff @(posedge aclk) begin
        coef_reg <= coef_next;
    end

    assign samp_q = samp_reg;
    assign coef_q = coef_reg;

endmodule

// ===== rtl/core/sgwf_mac.sv =====
`timescale 1ns / 1ps

module sgwf_mac (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  sgwf_pkg::mac_ctl_t                      ctl,
    input  logic signed [sgwf_pkg::SAMPLE_BITS-1:0] op_samp,
    input  logic signed [sgwf_pkg::COEF_BITS-1:0]   op_coef,
    input  logic                                    deriv_mode,
    input  logic [sgwf_pkg::RECIP_W-1:0]            recip_step,
    input  logic                                    res_take,
    output sgwf_pkg::mac_res_t                      res
);
    import sgwf_pkg::*;

    // operand stage
    mac_ctl_t                      s1_ctl_reg;
    logic signed [SAMPLE_BITS-1:0] s1_samp_reg;
    logic signed [COEF_BITS-1:0]   s1_coef_reg;

    // product stage
    logic                     s2_vld_reg, s2_first_reg, s2_last_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_next;

    // accumulator
    logic signed [ACC_W-1:0] acc_reg, acc_next, acc_base, prod_ext;
    logic                    done_reg;
    logic [ACC_W-1:0]        acc_abs;

    // magnitude
    logic             va_reg, neg_a_reg;
    logic [MAG_W-1:0] mag_a_reg;

    // split multiply by the reciprocal step
    logic             vb_reg, neg_b_reg;
    logic [MAG_W-1:0] mag_b_reg;
    logic [HI_W-1:0]  hi_reg, hi_next;
    logic [LO_W-1:0]  lo_reg, lo_next, lo_rnd;

    // rounding
    logic                  vc_reg, neg_c_reg, ovf_c_reg;
    logic [MAG_W-1:0]      mag_c_reg;
    logic [HI_LIM_BIT-1:0] hilo_c_reg;
    logic [RND_W-1:0]      rnd_c_reg;

    // scaled magnitude
    logic              vd_reg, neg_d_reg;
    logic [MAG2_W-1:0] mag2_reg, mag2_next, lim;

    // result, held until taken
    logic                res_vld_reg, res_sat_reg, sat_next;
    logic [OUT_BITS-1:0] res_val_reg, val_next, mag_out;

    always_comb begin
        // keep the multiply signed: operands sign-extend to the product width
        if (s1_ctl_reg.en) begin
            prod_next = s1_samp_reg * s1_coef_reg;
        end else begin
            prod_next = '0;
        end
        prod_ext  = ACC_W'(prod_reg);
        acc_base  = s2_first_reg ? '0 : acc_reg;
        acc_next  = acc_base + prod_ext;
        acc_abs   = acc_reg[ACC_W-1] ? (~acc_reg + 1'b1) : acc_reg;
        hi_next   = mag_a_reg[MAG_W-1:SPLIT_W] * recip_step;
        lo_next   = mag_a_reg[SPLIT_W-1:0] * recip_step;
        lo_rnd    = lo_reg + RND_HALF;
    end

    always_comb begin
        if (!deriv_mode) begin
            mag2_next = MAG2_W'(mag_c_reg);
        end else if (ovf_c_reg) begin
            mag2_next = OVF_MAG;
        end else begin
            mag2_next = MAG2_W'({hilo_c_reg, {FRAC_BITS{1'b0}}}) + MAG2_W'(rnd_c_reg);
        end
    end

    always_comb begin
        lim      = neg_d_reg ? LIM_NEG : LIM_POS;
        sat_next = (mag2_reg > lim);
        mag_out  = sat_next ? lim[OUT_BITS-1:0] : mag2_reg[OUT_BITS-1:0];
        val_next = neg_d_reg ? (~mag_out + 1'b1) : mag_out;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_ctl_reg   <= '0;
            s2_vld_reg   <= 1'b0;
            done_reg     <= 1'b0;
            va_reg       <= 1'b0;
            vb_reg       <= 1'b0;
            vc_reg       <= 1'b0;
            vd_reg       <= 1'b0;
            res_vld_reg  <= 1'b0;
        end else begin
            s1_ctl_reg   <= ctl;
            s2_vld_reg   <= s1_ctl_reg.vld;
            done_reg     <= s2_vld_reg && s2_last_reg;
            va_reg       <= done_reg;
            vb_reg       <= va_reg;
            vc_reg       <= vb_reg;
            vd_reg       <= vc_reg;
            if (vd_reg) begin
                res_vld_reg <= 1'b1;
            end else if (res_take) begin
                res_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        s1_samp_reg  <= op_samp;
        s1_coef_reg  <= op_coef;
        prod_reg     <= prod_next;
        s2_first_reg <= s1_ctl_reg.first;
        s2_last_reg  <= s1_ctl_reg.last;
        if (s2_vld_reg) begin
            acc_reg <= acc_next;
        end
        neg_a_reg  <= acc_reg[ACC_W-1];
        mag_a_reg  <= MAG_W'(acc_abs);
        neg_b_reg  <= neg_a_reg;
        mag_b_reg  <= mag_a_reg;
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        neg_c_reg  <= neg_b_reg;
        mag_c_reg  <= mag_b_reg;
        ovf_c_reg  <= |hi_reg[HI_W-1:HI_LIM_BIT];
        hilo_c_reg <= hi_reg[HI_LIM_BIT-1:0];
        rnd_c_reg  <= lo_rnd[LO_W-1:FRAC_BITS];
        neg_d_reg  <= neg_c_reg;
        mag2_reg   <= mag2_next;
        if (vd_reg) begin
            res_sat_reg <= sat_next;
            res_val_reg <= val_next;
        end
    end

    assign res.vld   = res_vld_reg;
    assign res.sat   = res_sat_reg;
    assign res.value = res_val_reg;

endmodule
